// ----- src/xsgen_pkg.sv -----
// ----------------------------------------------------------------------------
// xsgen_pkg
// Shared types, codes and helpers for the xoshiro128 generator with an
// entropy feed.
// ----------------------------------------------------------------------------
package xsgen_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CAPTURE_W = 12;
  localparam int unsigned CFG_IDX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_DRAW_PP = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW_SS = 2'd1;
  localparam logic [OP_W-1:0] OP_FEED    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SERIAL_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERIAL_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERIAL_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SERIAL_D = 2'd3;

  // four 32-bit state words, word 0 in the low slot
  typedef logic [3:0][WORD_W-1:0] pool_t;

  // one item moving from the input register into the execute logic
  typedef struct packed {
    logic                 go;
    logic [OP_W-1:0]      op;
    logic [CAPTURE_W-1:0] cap;
  } exec_t;

  // rotate left by a constant amount
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic logic is_draw(input logic [OP_W-1:0] op);
    return (op == OP_DRAW_PP) || (op == OP_DRAW_SS);
  endfunction

endpackage

// ----- src/xsgen_ifs.sv -----
// ----------------------------------------------------------------------------
// xsgen interfaces
// Valid/ready channels for input items and drawn words.
// ----------------------------------------------------------------------------
interface xsgen_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [xsgen_pkg::OP_W-1:0]           operation;
  logic [xsgen_pkg::WORD_W-1:0]         tick_count;
  logic [xsgen_pkg::CAPTURE_W-1:0]      capture_word;

  modport source (output valid, operation, tick_count, capture_word, input ready);
  modport sink   (input valid, operation, tick_count, capture_word, output ready);
endinterface

interface xsgen_result_if;
  logic                         valid;
  logic                         ready;
  logic [xsgen_pkg::WORD_W-1:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

// ----- src/xsgen_pool.sv -----
// ----------------------------------------------------------------------------
// xsgen_pool
// State register with the xoshiro128 update, zero reseed and byte feed.
// ----------------------------------------------------------------------------
module xsgen_pool (
  input  logic                  clk,
  input  logic                  rst,
  input  xsgen_pkg::exec_t      exec,
  input  xsgen_pkg::pool_t      seed,
  output xsgen_pkg::pool_t      drawn
);

  xsgen_pkg::pool_t pool;
  xsgen_pkg::pool_t pool_next;
  xsgen_pkg::pool_t advanced;
  xsgen_pkg::pool_t fed;
  logic [7:0]       feed_byte;
  logic [3:0]       feed_idx;

  // xoshiro128 state update
  always_comb begin
    advanced[2] = pool[2] ^ pool[0] ^ (pool[1] << 9);
    advanced[1] = pool[1] ^ pool[2] ^ pool[0];
    advanced[0] = pool[0] ^ pool[3] ^ pool[1];
    advanced[3] = xsgen_pkg::rotl(pool[3] ^ pool[1], 11);
  end

  // reseed when the updated state is all zero
  assign drawn = (advanced == '0) ? seed : advanced;

  // entropy byte into the selected state byte, little-endian across words
  assign feed_byte = exec.cap[7:0];
  assign feed_idx  = exec.cap[11:8];
  always_comb begin
    for (int w = 0; w < 4; w++) begin
      if (feed_idx[3:2] == w[1:0]) begin
        fed[w] = pool[w] ^ ({24'd0, feed_byte} << {feed_idx[1:0], 3'b000});
      end else begin
        fed[w] = pool[w];
      end
    end
  end

  // next state per operation
  always_comb begin
    pool_next = pool;
    if (exec.go) begin
      case (exec.op)
        xsgen_pkg::OP_DRAW_PP: pool_next = drawn;
        xsgen_pkg::OP_DRAW_SS: pool_next = drawn;
        xsgen_pkg::OP_FEED:    pool_next = fed;
        default:               pool_next = pool;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= '0;
    end else begin
      pool <= pool_next;
    end
  end

endmodule

// ----- src/xsgen_mix.sv -----
// ----------------------------------------------------------------------------
// xsgen_mix
// Output scrambler (plus-plus or star-star) and the result register.
// ----------------------------------------------------------------------------
module xsgen_mix (
  input  logic                          clk,
  input  logic                          rst,
  input  xsgen_pkg::exec_t              exec,
  input  xsgen_pkg::pool_t              drawn,
  xsgen_result_if.source                result
);

  logic [xsgen_pkg::WORD_W-1:0] pp_value;
  logic [xsgen_pkg::WORD_W-1:0] ss_times5;
  logic [xsgen_pkg::WORD_W-1:0] ss_rot;
  logic [xsgen_pkg::WORD_W-1:0] ss_value;
  logic [xsgen_pkg::WORD_W-1:0] mixed;
  logic                         load;
  logic                         valid;
  logic [xsgen_pkg::WORD_W-1:0] value;

  // plus-plus: rotl(w0 + w3, 7) + w0
  assign pp_value = xsgen_pkg::rotl(drawn[0] + drawn[3], 7) + drawn[0];

  // star-star: rotl(w1 * 5, 7) * 9, constant multiplies as shift-adds
  assign ss_times5 = drawn[1] + (drawn[1] << 2);
  assign ss_rot    = xsgen_pkg::rotl(ss_times5, 7);
  assign ss_value  = ss_rot + (ss_rot << 3);

  assign mixed = (exec.op == xsgen_pkg::OP_DRAW_SS) ? ss_value : pp_value;
  assign load  = exec.go && xsgen_pkg::is_draw(exec.op);

  // result register, drained by a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= mixed;
    end
  end

  assign result.valid        = valid;
  assign result.random_value = value;

endmodule

// ----- src/xoshiro128_generator_with_entropy_feed_top.sv -----
// ----------------------------------------------------------------------------
// xoshiro128_generator_with_entropy_feed_top
// xoshiro128 generator with plus-plus/star-star draws and an entropy feed.
//
//   channel   dir   contents
//   item      in    operation, tick_count, capture_word
//   result    out   random_value (one per draw, none for feed)
//   cfg_*     in    serial words a..d, write only
//
// One item per cycle sustained while draw results are taken; a draw's item
// goes through the input register, then its word into the result register.
// The state update, reseed and scrambler sit between those two registers.
// A stalled result holds; feeds keep flowing past it, draws wait for it.
// Reset clears the state and serial words; a draw from all-zero state seeds it.
// ----------------------------------------------------------------------------
module xoshiro128_generator_with_entropy_feed_top (
  input  logic                                clk,
  input  logic                                rst,
  xsgen_item_if.sink                          item,
  xsgen_result_if.source                      result,
  input  logic                                cfg_write,
  input  logic [xsgen_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [xsgen_pkg::WORD_W-1:0]        cfg_data
);

  logic [xsgen_pkg::WORD_W-1:0]    serial_a;
  logic [xsgen_pkg::WORD_W-1:0]    serial_b;
  logic [xsgen_pkg::WORD_W-1:0]    serial_c;
  logic [xsgen_pkg::WORD_W-1:0]    serial_d;
  logic                            stage_valid;
  logic [xsgen_pkg::OP_W-1:0]      stage_op;
  logic [xsgen_pkg::WORD_W-1:0]    stage_tick;
  logic [xsgen_pkg::CAPTURE_W-1:0] stage_cap;
  logic                            advance;
  xsgen_pkg::exec_t                exec;
  xsgen_pkg::pool_t                seed;
  xsgen_pkg::pool_t                drawn;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      serial_a <= '0;
      serial_b <= '0;
      serial_c <= '0;
      serial_d <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        xsgen_pkg::REG_SERIAL_A: serial_a <= cfg_data;
        xsgen_pkg::REG_SERIAL_B: serial_b <= cfg_data;
        xsgen_pkg::REG_SERIAL_C: serial_c <= cfg_data;
        xsgen_pkg::REG_SERIAL_D: serial_d <= cfg_data;
        default: ;
      endcase
    end
  end

  // a draw needs the result register free or draining; others always go
  assign advance = stage_valid &&
                   (!xsgen_pkg::is_draw(stage_op) || !result.valid || result.ready);
  assign item.ready = !stage_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_op   <= item.operation;
      stage_tick <= item.tick_count;
      stage_cap  <= item.capture_word;
    end
  end

  assign exec.go   = advance;
  assign exec.op   = stage_op;
  assign exec.cap  = stage_cap;

  // seed words, tick folded into the first two
  assign seed[0] = serial_a ^ stage_tick;
  assign seed[1] = serial_b ^ stage_tick;
  assign seed[2] = serial_c;
  assign seed[3] = serial_d;

  xsgen_pool u_pool (
    .clk   (clk),
    .rst   (rst),
    .exec  (exec),
    .seed  (seed),
    .drawn (drawn)
  );

  xsgen_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .exec   (exec),
    .drawn  (drawn),
    .result (result)
  );

  // an executed draw always lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    (advance && xsgen_pkg::is_draw(stage_op)) |=> result.valid)
    else $error("executed draw did not produce a result");

  // a held item in the input register is not lost or changed
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> (stage_valid && $stable(stage_op) &&
                                   $stable(stage_cap) && $stable(stage_tick)))
    else $error("stalled item in input register was disturbed");

  // a draw never executes over an undelivered result
  assert property (@(posedge clk) disable iff (rst)
    (advance && xsgen_pkg::is_draw(stage_op)) |-> (!result.valid || result.ready))
    else $error("draw overwrote a pending result");

endmodule
